// ----- hw/rtl/pbpc_pkg.sv -----
// shared types and constants for the port based packet classifier
package pbpc_pkg;

    // field widths
    localparam int BYTE_WIDTH      = 8;
    localparam int PORT_WIDTH      = 16;
    localparam int POS_WIDTH       = 7;
    localparam int LEN_WIDTH       = 8;
    localparam int TOTAL_WIDTH     = 64;
    localparam int CFG_INDEX_WIDTH = 2;

    // class counter width, 16 to 64 bits
    localparam int COUNTER_WIDTH = 64;
    localparam logic [COUNTER_WIDTH-1:0] COUNT_ONE = COUNTER_WIDTH'(1);

    // frame layout
    localparam logic [POS_WIDTH-1:0] POS_MAX         = 7'd127;
    localparam logic [POS_WIDTH-1:0] POS_ETYPE_HI    = 7'd12;
    localparam logic [POS_WIDTH-1:0] POS_ETYPE_LO    = 7'd13;
    localparam logic [POS_WIDTH-1:0] POS_IHL         = 7'd14;
    localparam logic [POS_WIDTH-1:0] POS_PROTO       = 7'd23;
    localparam logic [POS_WIDTH-1:0] ETH_HDR_POS     = 7'd14;
    localparam logic [LEN_WIDTH-1:0] ETH_HDR_LEN     = 8'd14;
    localparam logic [LEN_WIDTH-1:0] MIN_IP_FRAME    = 8'd34;
    localparam logic [LEN_WIDTH-1:0] TCP_HDR_LEN     = 8'd20;
    localparam logic [LEN_WIDTH-1:0] UDP_HDR_LEN     = 8'd8;
    localparam logic [3:0]           IHL_MIN         = 4'd5;
    localparam logic [15:0]          ETYPE_IPV4      = 16'h0800;
    localparam logic [7:0]           PROTO_TCP       = 8'd6;
    localparam logic [7:0]           PROTO_UDP       = 8'd17;

    // configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_HTTP_PORT = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SSH_PORT  = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DNS_PORT  = 2'd2;

    // traffic class codes
    typedef enum logic [1:0] {
        CLASS_NONE = 2'd0,
        CLASS_HTTP = 2'd1,
        CLASS_DNS  = 2'd2,
        CLASS_SSH  = 2'd3
    } traffic_class_t;

    // header fields as they stand after the current byte
    typedef struct packed {
        logic [15:0]           ether_type;
        logic [3:0]            header_words;
        logic [7:0]            transport_proto;
        logic [PORT_WIDTH-1:0] source_port;
        logic [PORT_WIDTH-1:0] dest_port;
        logic [LEN_WIDTH-1:0]  frame_len;
    } hdr_t;

endpackage

// ----- hw/rtl/pbpc_parser.sv -----
// header field capture from the byte stream
module pbpc_parser import pbpc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  byte_valid,
    input  logic [BYTE_WIDTH-1:0] frame_byte,
    input  logic                  frame_end,
    output hdr_t                  hdr
);

    logic [POS_WIDTH-1:0]  pos_reg,   pos_next;
    logic [15:0]           etype_reg, etype_next;
    logic [3:0]            words_reg, words_next;
    logic [7:0]            proto_reg, proto_next;
    logic [PORT_WIDTH-1:0] sport_reg, sport_next;
    logic [PORT_WIDTH-1:0] dport_reg, dport_next;

    hdr_t                 cap;
    logic [POS_WIDTH-1:0] l4_pos;

    // transport header offset from the ihl seen so far
    assign l4_pos = ETH_HDR_POS + {1'b0, words_reg, 2'b00};

    // capture the current byte into the header fields
    always_comb begin
        cap.ether_type      = etype_reg;
        cap.header_words    = words_reg;
        cap.transport_proto = proto_reg;
        cap.source_port     = sport_reg;
        cap.dest_port       = dport_reg;
        cap.frame_len       = {1'b0, pos_reg} + 8'd1;
        if (pos_reg != POS_MAX) begin
            priority if (pos_reg == POS_ETYPE_HI) begin
                cap.ether_type[15:8] = frame_byte;
            end else if (pos_reg == POS_ETYPE_LO) begin
                cap.ether_type[7:0] = frame_byte;
            end else if (pos_reg == POS_IHL) begin
                cap.header_words = frame_byte[3:0];
            end else if (pos_reg == POS_PROTO) begin
                cap.transport_proto = frame_byte;
            end else begin
                // no ip header field at this offset
            end
            priority if (pos_reg == l4_pos) begin
                cap.source_port[15:8] = frame_byte;
            end else if (pos_reg == l4_pos + 7'd1) begin
                cap.source_port[7:0] = frame_byte;
            end else if (pos_reg == l4_pos + 7'd2) begin
                cap.dest_port[15:8] = frame_byte;
            end else if (pos_reg == l4_pos + 7'd3) begin
                cap.dest_port[7:0] = frame_byte;
            end else begin
                // no port byte at this offset
            end
        end
    end

    assign hdr = cap;

    // next state: advance, or clear at frame end
    always_comb begin
        pos_next   = pos_reg;
        etype_next = etype_reg;
        words_next = words_reg;
        proto_next = proto_reg;
        sport_next = sport_reg;
        dport_next = dport_reg;
        if (byte_valid) begin
            if (frame_end) begin
                pos_next   = '0;
                etype_next = '0;
                words_next = '0;
                proto_next = '0;
                sport_next = '0;
                dport_next = '0;
            end else begin
                pos_next   = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + 7'd1;
                etype_next = cap.ether_type;
                words_next = cap.header_words;
                proto_next = cap.transport_proto;
                sport_next = cap.source_port;
                dport_next = cap.dest_port;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            etype_reg <= '0;
            words_reg <= '0;
            proto_reg <= '0;
            sport_reg <= '0;
            dport_reg <= '0;
        end else begin
            pos_reg   <= pos_next;
            etype_reg <= etype_next;
            words_reg <= words_next;
            proto_reg <= proto_next;
            sport_reg <= sport_next;
            dport_reg <= dport_next;
        end
    end

endmodule

// ----- hw/rtl/pbpc_class_cnt.sv -----
// frame classification and per-class counters
module pbpc_class_cnt import pbpc_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     frame_done,
    input  hdr_t                     hdr,
    input  logic [PORT_WIDTH-1:0]    http_port,
    input  logic [PORT_WIDTH-1:0]    ssh_port,
    input  logic [PORT_WIDTH-1:0]    dns_port,
    output traffic_class_t           traffic_class,
    output logic [COUNTER_WIDTH-1:0] class_total
);

    logic [COUNTER_WIDTH-1:0] http_cnt_reg, http_cnt_next;
    logic [COUNTER_WIDTH-1:0] dns_cnt_reg,  dns_cnt_next;
    logic [COUNTER_WIDTH-1:0] ssh_cnt_reg,  ssh_cnt_next;

    traffic_class_t       cls;
    logic [LEN_WIDTH-1:0] l4_len;
    logic                 ip_ok;
    logic                 hit_http, hit_ssh, hit_dns;

    assign l4_len   = ETH_HDR_LEN + {2'b00, hdr.header_words, 2'b00};
    assign ip_ok    = (hdr.ether_type == ETYPE_IPV4) && (hdr.frame_len >= MIN_IP_FRAME)
                      && (hdr.header_words >= IHL_MIN);
    assign hit_http = (hdr.source_port == http_port) || (hdr.dest_port == http_port);
    assign hit_ssh  = (hdr.source_port == ssh_port)  || (hdr.dest_port == ssh_port);
    assign hit_dns  = (hdr.source_port == dns_port)  || (hdr.dest_port == dns_port);

    // class decision, http before ssh
    always_comb begin
        cls = CLASS_NONE;
        if (ip_ok) begin
            priority if (hdr.transport_proto == PROTO_TCP) begin
                if (hdr.frame_len >= l4_len + TCP_HDR_LEN) begin
                    priority if (hit_http) begin
                        cls = CLASS_HTTP;
                    end else if (hit_ssh) begin
                        cls = CLASS_SSH;
                    end else begin
                        cls = CLASS_NONE;
                    end
                end
            end else if (hdr.transport_proto == PROTO_UDP) begin
                if (hdr.frame_len >= l4_len + UDP_HDR_LEN && hit_dns) begin
                    cls = CLASS_DNS;
                end
            end else begin
                cls = CLASS_NONE;
            end
        end
    end

    // counter increment for the matched class
    always_comb begin
        http_cnt_next = http_cnt_reg;
        dns_cnt_next  = dns_cnt_reg;
        ssh_cnt_next  = ssh_cnt_reg;
        class_total   = '0;
        unique case (cls)
            CLASS_HTTP: begin
                class_total = http_cnt_reg + COUNT_ONE;
                if (frame_done) begin
                    http_cnt_next = class_total;
                end
            end
            CLASS_DNS: begin
                class_total = dns_cnt_reg + COUNT_ONE;
                if (frame_done) begin
                    dns_cnt_next = class_total;
                end
            end
            CLASS_SSH: begin
                class_total = ssh_cnt_reg + COUNT_ONE;
                if (frame_done) begin
                    ssh_cnt_next = class_total;
                end
            end
            default: begin
                class_total = '0;
            end
        endcase
    end

    assign traffic_class = cls;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            http_cnt_reg <= '0;
            dns_cnt_reg  <= '0;
            ssh_cnt_reg  <= '0;
        end else begin
            http_cnt_reg <= http_cnt_next;
            dns_cnt_reg  <= dns_cnt_next;
            ssh_cnt_reg  <= ssh_cnt_next;
        end
    end

endmodule

// ----- hw/rtl/port_based_packet_classifier_unit.sv -----
// top level of the port based packet classifier
//
// Frame bytes enter one per cycle on the s_ channel while s_ready is high, the
// last byte flagged by s_frame_end. Each byte is held in an input register and,
// once it moves on, goes through header capture, and on the last byte through
// classification and a counter increment, into the result register, so the
// result for a frame passes the input register and then the result register
// before it appears on m_. Only last bytes need the result register:
// s_ready drops only while the input register holds a last byte and an
// earlier result is still waiting for m_ready. Port registers are written on
// the cfg_ channel (index 0 http, 1 ssh, 2 dns; index 3 is ignored) and are
// always ready.
module port_based_packet_classifier_unit import pbpc_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    // frame bytes
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [BYTE_WIDTH-1:0]      s_frame_byte,
    input  logic                       s_frame_end,
    // classification results
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_traffic_class,
    output logic [TOTAL_WIDTH-1:0]     m_class_total,
    // register writes
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [PORT_WIDTH-1:0]      cfg_data
);

    logic [PORT_WIDTH-1:0] http_port_reg, ssh_port_reg, dns_port_reg;

    logic                  in_valid_reg, in_valid_next;
    logic [BYTE_WIDTH-1:0] in_byte_reg;
    logic                  in_end_reg;

    logic                  out_valid_reg, out_valid_next;
    traffic_class_t        out_class_reg;
    logic [TOTAL_WIDTH-1:0] out_total_reg;

    logic                     advance;
    logic                     frame_done;
    hdr_t                     hdr;
    traffic_class_t           cls;
    logic [COUNTER_WIDTH-1:0] cls_total;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            http_port_reg <= '0;
            ssh_port_reg  <= '0;
            dns_port_reg  <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_HTTP_PORT: http_port_reg <= cfg_data;
                CFG_SSH_PORT:  ssh_port_reg  <= cfg_data;
                CFG_DNS_PORT:  dns_port_reg  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input register moves on unless a result has nowhere to go
    assign advance    = in_valid_reg && (!in_end_reg || !out_valid_reg || m_ready);
    assign frame_done = advance && in_end_reg;
    assign s_ready    = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_frame_byte;
            in_end_reg  <= s_frame_end;
        end
    end

    pbpc_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (advance),
        .frame_byte (in_byte_reg),
        .frame_end  (in_end_reg),
        .hdr        (hdr)
    );

    pbpc_class_cnt u_class_cnt (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .frame_done    (frame_done),
        .hdr           (hdr),
        .http_port     (http_port_reg),
        .ssh_port      (ssh_port_reg),
        .dns_port      (dns_port_reg),
        .traffic_class (cls),
        .class_total   (cls_total)
    );

    // result register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (frame_done) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (frame_done) begin
            out_class_reg <= cls;
            out_total_reg <= TOTAL_WIDTH'(cls_total);
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_traffic_class = out_class_reg;
    assign m_class_total   = out_total_reg;

    // a new result only follows a last byte leaving the input register
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_valid_reg && in_end_reg))
        else $error("result appeared without a frame end");

    // unmatched frames report a zero total
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_class_reg == CLASS_NONE) |-> (out_total_reg == '0))
        else $error("unmatched result with nonzero total");

    // a held byte is neither dropped nor overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)
                                        && $stable(in_end_reg)))
        else $error("stalled input byte lost");

endmodule
